// ===== src/byte_stream_token_lexer_top_assert.svh =====
// Assertion macros for the byte stream token lexer checker.
// Depends on nothing; included by the checker file.
`ifndef BYTE_STREAM_TOKEN_LEXER_TOP_ASSERT_SVH
`define BYTE_STREAM_TOKEN_LEXER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BSTL_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BSTL_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bstl_pkg.sv =====
// Shared types, constants and the byte classifier of the token lexer.
// No dependencies; imported by every lexer module.
`default_nettype none

package bstl_pkg;

  localparam int CH_W   = 8;
  localparam int KIND_W = 4;
  localparam int POS_W  = 32;
  localparam int LINE_W = 24;
  localparam int COL_W  = 16;
  localparam int VAL_W  = 64;
  localparam int DIG_W  = 4;

  // Item queue between front and back (power of two depth)
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // Token queue in front of the output port (power of two depth)
  localparam int ODEPTH = 4;
  localparam int OPTR_W = $clog2(ODEPTH);
  localparam int OCNT_W = OPTR_W + 1;

  // Character codes
  localparam logic [CH_W-1:0] ASC_NUL    = 8'h00;
  localparam logic [CH_W-1:0] ASC_TAB    = 8'h09;
  localparam logic [CH_W-1:0] ASC_LF     = 8'h0A;
  localparam logic [CH_W-1:0] ASC_CR     = 8'h0D;
  localparam logic [CH_W-1:0] ASC_SPACE  = 8'h20;
  localparam logic [CH_W-1:0] ASC_PCT    = 8'h25;
  localparam logic [CH_W-1:0] ASC_AMP    = 8'h26;
  localparam logic [CH_W-1:0] ASC_LPAR   = 8'h28;
  localparam logic [CH_W-1:0] ASC_RPAR   = 8'h29;
  localparam logic [CH_W-1:0] ASC_STAR   = 8'h2A;
  localparam logic [CH_W-1:0] ASC_PLUS   = 8'h2B;
  localparam logic [CH_W-1:0] ASC_COMMA  = 8'h2C;
  localparam logic [CH_W-1:0] ASC_MINUS  = 8'h2D;
  localparam logic [CH_W-1:0] ASC_SLASH  = 8'h2F;
  localparam logic [CH_W-1:0] ASC_ZERO   = 8'h30;
  localparam logic [CH_W-1:0] ASC_NINE   = 8'h39;
  localparam logic [CH_W-1:0] ASC_SEMI   = 8'h3B;
  localparam logic [CH_W-1:0] ASC_EQUAL  = 8'h3D;
  localparam logic [CH_W-1:0] ASC_UP_A   = 8'h41;
  localparam logic [CH_W-1:0] ASC_UP_Z   = 8'h5A;
  localparam logic [CH_W-1:0] ASC_UNDER  = 8'h5F;
  localparam logic [CH_W-1:0] ASC_LOW_A  = 8'h61;
  localparam logic [CH_W-1:0] ASC_LOW_Z  = 8'h7A;
  localparam logic [CH_W-1:0] ASC_BAR    = 8'h7C;

  typedef enum logic [KIND_W-1:0] {
    K_EOF     = 4'd0,
    K_PLUS    = 4'd1,
    K_MINUS   = 4'd2,
    K_STAR    = 4'd3,
    K_SLASH   = 4'd4,
    K_PERCENT = 4'd5,
    K_AMP     = 4'd6,
    K_BAR     = 4'd7,
    K_EQUAL   = 4'd8,
    K_LPAREN  = 4'd9,
    K_RPAREN  = 4'd10,
    K_COMMA   = 4'd11,
    K_SEMI    = 4'd12,
    K_INT     = 4'd13,
    K_IDENT   = 4'd14,
    K_UNKNOWN = 4'd15
  } kind_t;

  typedef enum logic [2:0] {
    CL_WS,
    CL_NL,
    CL_DIGIT,
    CL_ALPHA,
    CL_OP,
    CL_EOF,
    CL_UNKNOWN
  } cls_t;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_INT,
    MODE_IDENT
  } mode_t;

  typedef struct packed {
    cls_t              cls;
    kind_t             op;
    logic [DIG_W-1:0]  digit;
  } item_t;

  typedef struct packed {
    kind_t              kind;
    logic [POS_W-1:0]   start_pos;
    logic [LINE_W-1:0]  start_line;
    logic [COL_W-1:0]   start_col;
    logic [POS_W-1:0]   end_pos;
    logic [LINE_W-1:0]  end_line;
    logic [COL_W-1:0]   end_col;
    logic [VAL_W-1:0]   int_value;
    logic               overflow;
    logic               last;
  } token_t;

  // Up to two tokens written into the output queue per cycle
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } tok_push_t;

  function automatic item_t classify(input logic [CH_W-1:0] c);
    item_t it;
    it.cls   = CL_UNKNOWN;
    it.op    = K_EOF;
    it.digit = c[DIG_W-1:0];
    unique case (c) inside
      ASC_TAB, ASC_CR, ASC_SPACE:       it.cls = CL_WS;
      ASC_LF:                           it.cls = CL_NL;
      ASC_NUL:                          it.cls = CL_EOF;
      [ASC_ZERO:ASC_NINE]:              it.cls = CL_DIGIT;
      [ASC_UP_A:ASC_UP_Z], [ASC_LOW_A:ASC_LOW_Z], ASC_UNDER:
                                        it.cls = CL_ALPHA;
      ASC_PLUS:  begin it.cls = CL_OP; it.op = K_PLUS;    end
      ASC_MINUS: begin it.cls = CL_OP; it.op = K_MINUS;   end
      ASC_STAR:  begin it.cls = CL_OP; it.op = K_STAR;    end
      ASC_SLASH: begin it.cls = CL_OP; it.op = K_SLASH;   end
      ASC_PCT:   begin it.cls = CL_OP; it.op = K_PERCENT; end
      ASC_AMP:   begin it.cls = CL_OP; it.op = K_AMP;     end
      ASC_BAR:   begin it.cls = CL_OP; it.op = K_BAR;     end
      ASC_EQUAL: begin it.cls = CL_OP; it.op = K_EQUAL;   end
      ASC_LPAR:  begin it.cls = CL_OP; it.op = K_LPAREN;  end
      ASC_RPAR:  begin it.cls = CL_OP; it.op = K_RPAREN;  end
      ASC_COMMA: begin it.cls = CL_OP; it.op = K_COMMA;   end
      ASC_SEMI:  begin it.cls = CL_OP; it.op = K_SEMI;    end
      default:                          it.cls = CL_UNKNOWN;
    endcase
    return it;
  endfunction

endpackage

`default_nettype wire

// ===== src/bstl_front.sv =====
// Front end of the lexer: accepts source bytes and classifies them.
// Depends on bstl_pkg; feeds bstl_queue.
`default_nettype none

module bstl_front import bstl_pkg::*; (
  input  logic            ch_valid,
  input  logic [CH_W-1:0] ch,
  output logic            ch_stall,
  input  logic            q_full,
  output logic            push,
  output item_t           push_item
);

  // hold the source while the item queue is full
  assign ch_stall  = q_full;
  assign push      = ch_valid && !q_full;
  assign push_item = classify(ch);

endmodule

`default_nettype wire

// ===== src/bstl_queue.sv =====
// Short queue of classified bytes between the lexer front and back.
// Depends on bstl_pkg.
`default_nettype none

module bstl_queue import bstl_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  item_t  push_item,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output item_t  head_item
);

  item_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign empty     = (count == '0);
  assign head_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== src/bstl_back.sv =====
// Back end of the lexer: scanner state, counters and token building.
// Depends on bstl_pkg; drains bstl_queue and fills bstl_out.
`default_nettype none

module bstl_back import bstl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  item_t      head_item,
  output logic       pop,
  input  logic       out_room,
  output tok_push_t  tok_push
);

  mode_t              mode, mode_next;
  logic [POS_W-1:0]   position, position_next;
  logic [LINE_W-1:0]  line_count, line_count_next;
  logic [COL_W-1:0]   column, column_next;
  logic [POS_W-1:0]   tok_start_pos, tok_start_pos_next;
  logic [COL_W-1:0]   tok_start_col, tok_start_col_next;
  logic [VAL_W-1:0]   accumulator, accumulator_next;
  logic               acc_overflow, acc_overflow_next;
  logic               halted, halted_next;

  logic               fire;
  logic               cont;
  logic               pend;
  logic               cur;
  logic [VAL_W+3:0]   acc_wide;
  logic [POS_W-1:0]   pos_inc;
  logic [POS_W-1:0]   epos;
  logic [COL_W-1:0]   col_inc;
  logic [COL_W-1:0]   ecol;
  logic [LINE_W-1:0]  line_inc;
  token_t             pend_tok;
  token_t             cur_tok;

  assign fire = !q_empty && out_room;
  assign pop  = fire;

  // saturating counters
  assign pos_inc  = (&position)   ? position   : position + POS_W'(1);
  assign col_inc  = (&column)     ? column     : column + COL_W'(1);
  assign line_inc = (&line_count) ? line_count : line_count + LINE_W'(1);
  assign epos     = (position != '0) ? position - POS_W'(1) : '0;
  assign ecol     = (column > COL_W'(1)) ? column - COL_W'(1) : COL_W'(1);

  // acc * 10 + digit, with carry bits to flag wrap
  assign acc_wide = {1'b0, accumulator, 3'b000} + {3'b000, accumulator, 1'b0}
                  + {{VAL_W{1'b0}}, head_item.digit};

  assign cont = (mode == MODE_INT && head_item.cls == CL_DIGIT)
             || (mode == MODE_IDENT
                 && (head_item.cls == CL_DIGIT || head_item.cls == CL_ALPHA));
  assign pend = !cont && (mode == MODE_INT || mode == MODE_IDENT);
  assign cur  = !cont && (head_item.cls == CL_OP || head_item.cls == CL_EOF
                          || head_item.cls == CL_UNKNOWN);

  // next state
  always_comb begin
    mode_next          = mode;
    position_next      = position;
    line_count_next    = line_count;
    column_next        = column;
    tok_start_pos_next = tok_start_pos;
    tok_start_col_next = tok_start_col;
    accumulator_next   = accumulator;
    acc_overflow_next  = acc_overflow;
    halted_next        = halted;
    if (fire && !halted) begin
      if (cont) begin
        if (mode == MODE_INT) begin
          accumulator_next = acc_wide[VAL_W-1:0];
          if (|acc_wide[VAL_W+3:VAL_W]) begin
            acc_overflow_next = 1'b1;
          end
        end
        position_next = pos_inc;
        column_next   = col_inc;
      end else begin
        mode_next = MODE_IDLE;
        unique case (head_item.cls)
          CL_NL: begin
            line_count_next = line_inc;
            column_next     = COL_W'(1);
            position_next   = pos_inc;
          end
          CL_WS, CL_OP: begin
            position_next = pos_inc;
            column_next   = col_inc;
          end
          CL_DIGIT: begin
            mode_next          = MODE_INT;
            tok_start_pos_next = position;
            tok_start_col_next = column;
            accumulator_next   = VAL_W'(head_item.digit);
            acc_overflow_next  = 1'b0;
            position_next      = pos_inc;
            column_next        = col_inc;
          end
          CL_ALPHA: begin
            mode_next          = MODE_IDENT;
            tok_start_pos_next = position;
            tok_start_col_next = column;
            position_next      = pos_inc;
            column_next        = col_inc;
          end
          CL_EOF, CL_UNKNOWN: begin
            halted_next = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // token outputs
  always_comb begin
    pend_tok.kind       = (mode == MODE_INT) ? K_INT : K_IDENT;
    pend_tok.start_pos  = tok_start_pos;
    pend_tok.start_line = line_count;
    pend_tok.start_col  = tok_start_col;
    pend_tok.end_pos    = epos;
    pend_tok.end_line   = line_count;
    pend_tok.end_col    = ecol;
    pend_tok.int_value  = (mode == MODE_INT) ? accumulator : '0;
    pend_tok.overflow   = (mode == MODE_INT) && acc_overflow;
    pend_tok.last       = !cur;

    cur_tok.kind        = (head_item.cls == CL_OP)  ? head_item.op :
                          (head_item.cls == CL_EOF) ? K_EOF : K_UNKNOWN;
    cur_tok.start_pos   = position;
    cur_tok.start_line  = line_count;
    cur_tok.start_col   = column;
    cur_tok.end_pos     = position;
    cur_tok.end_line    = line_count;
    cur_tok.end_col     = column;
    cur_tok.int_value   = '0;
    cur_tok.overflow    = 1'b0;
    cur_tok.last        = 1'b1;

    tok_push.count  = 2'd0;
    tok_push.first  = pend ? pend_tok : cur_tok;
    tok_push.second = cur_tok;
    if (fire && !halted) begin
      tok_push.count = 2'(pend) + 2'(cur);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      position      <= '0;
      line_count    <= LINE_W'(1);
      column        <= COL_W'(1);
      tok_start_pos <= '0;
      tok_start_col <= COL_W'(1);
      accumulator   <= '0;
      acc_overflow  <= 1'b0;
      halted        <= 1'b0;
    end else begin
      mode          <= mode_next;
      position      <= position_next;
      line_count    <= line_count_next;
      column        <= column_next;
      tok_start_pos <= tok_start_pos_next;
      tok_start_col <= tok_start_col_next;
      accumulator   <= accumulator_next;
      acc_overflow  <= acc_overflow_next;
      halted        <= halted_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/bstl_out.sv =====
// Output token queue: takes up to two tokens per cycle, sends one.
// Depends on bstl_pkg; drives the token port of the top level.
`default_nettype none

module bstl_out import bstl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  tok_push_t  tok_push,
  output logic       out_room,
  output logic       tok_valid,
  input  logic       tok_stall,
  output token_t     head_tok
);

  token_t            slots [ODEPTH];
  logic [OPTR_W-1:0] wr_ptr;
  logic [OPTR_W-1:0] wr_ptr_second;
  logic [OPTR_W-1:0] rd_ptr;
  logic [OCNT_W-1:0] count;
  logic              pop;

  assign wr_ptr_second = wr_ptr + OPTR_W'(1);
  assign out_room      = (count <= OCNT_W'(ODEPTH - 2));
  assign tok_valid     = (count != '0);
  assign head_tok      = slots[rd_ptr];
  assign pop           = tok_valid && !tok_stall;

  always_ff @(posedge clk) begin
    if (tok_push.count != 2'd0) begin
      slots[wr_ptr] <= tok_push.first;
    end
    if (tok_push.count == 2'd2) begin
      slots[wr_ptr_second] <= tok_push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OPTR_W'(tok_push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + OPTR_W'(1);
      end
      count <= count + OCNT_W'(tok_push.count) - OCNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== src/byte_stream_token_lexer_top.sv =====
// Top level of the byte stream token lexer.
// Depends on bstl_pkg, bstl_front, bstl_queue, bstl_back and bstl_out.
//
// Usage:
//   Source bytes arrive on the ch channel (ch_valid / ch_stall), one byte
//   per transfer; a NUL byte marks end of input. Tokens leave on the tok
//   channel (tok_valid / tok_stall), one token per transfer, each with its
//   kind, start and end offsets, line, columns, integer value and overflow.
//   last marks the final token caused by one source byte.
// Order: a byte passes through the byte queue and then the token queue before
//   its tokens reach the tok channel; an integer or identifier that a byte
//   ends comes first, and the byte's own token follows it.
// Throughput: one byte per cycle while the token queue has room, set by the
//   single back-end step per byte; a byte that yields two tokens occupies
//   the token port for two transfers.
// Stall: when tok_stall holds, the back end stops once more than two of the
//   four token queue entries are in use, the two-entry byte queue then fills,
//   and ch_stall rises once that queue is full.
// Reset: rst (synchronous) empties both queues and returns the scanner to
//   line 1, column 1, offset 0. After an end-of-file or unknown-character
//   token the block drops every further byte until reset.
`default_nettype none

module byte_stream_token_lexer_top import bstl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              ch_valid,
  output logic              ch_stall,
  input  logic [CH_W-1:0]   ch,
  output logic              tok_valid,
  input  logic              tok_stall,
  output logic [KIND_W-1:0] kind,
  output logic [POS_W-1:0]  start_pos,
  output logic [LINE_W-1:0] start_line,
  output logic [COL_W-1:0]  start_col,
  output logic [POS_W-1:0]  end_pos,
  output logic [LINE_W-1:0] end_line,
  output logic [COL_W-1:0]  end_col,
  output logic [VAL_W-1:0]  int_value,
  output logic              overflow,
  output logic              last
);

  logic      q_push;
  item_t     q_push_item;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  item_t     q_head;
  logic      out_room;
  tok_push_t tok_push;
  token_t    head_tok;

  // classify incoming bytes
  bstl_front u_front (
    .ch_valid  (ch_valid),
    .ch        (ch),
    .ch_stall  (ch_stall),
    .q_full    (q_full),
    .push      (q_push),
    .push_item (q_push_item)
  );

  // decouple front from back
  bstl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_item (q_head)
  );

  // advance the scanner one byte per cycle while the token queue has room
  bstl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head_item (q_head),
    .pop       (q_pop),
    .out_room  (out_room),
    .tok_push  (tok_push)
  );

  // hold finished tokens until the receiver takes them
  bstl_out u_out (
    .clk       (clk),
    .rst       (rst),
    .tok_push  (tok_push),
    .out_room  (out_room),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .head_tok  (head_tok)
  );

  assign kind       = head_tok.kind;
  assign start_pos  = head_tok.start_pos;
  assign start_line = head_tok.start_line;
  assign start_col  = head_tok.start_col;
  assign end_pos    = head_tok.end_pos;
  assign end_line   = head_tok.end_line;
  assign end_col    = head_tok.end_col;
  assign int_value  = head_tok.int_value;
  assign overflow   = head_tok.overflow;
  assign last       = head_tok.last;

endmodule

`default_nettype wire

// ===== src/bstl_checker.sv =====
// Port-level checker for the byte stream token lexer, bound to the top.
// Depends on bstl_pkg and byte_stream_token_lexer_top_assert.svh.
`default_nettype none

`include "byte_stream_token_lexer_top_assert.svh"

module bstl_checker import bstl_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              tok_valid,
  input logic              tok_stall,
  input logic [KIND_W-1:0] kind,
  input logic [POS_W-1:0]  start_pos,
  input logic [LINE_W-1:0] start_line,
  input logic [COL_W-1:0]  start_col,
  input logic [POS_W-1:0]  end_pos,
  input logic [LINE_W-1:0] end_line,
  input logic [COL_W-1:0]  end_col,
  input logic [VAL_W-1:0]  int_value,
  input logic              overflow,
  input logic              last
);

  // a stalled token holds
  `BSTL_ASSERT_NEXT(a_tok_hold, clk, rst, tok_valid && tok_stall, tok_valid && $stable(kind) && $stable(start_pos) && $stable(last), "stalled token changed")

  // single-byte terminal tokens cover exactly one position
  `BSTL_ASSERT_NOW(a_term_span, clk, rst, tok_valid && (kind == K_EOF || kind == K_UNKNOWN), end_pos == start_pos && end_col == start_col, "terminal token span wrong")

  // only integer tokens carry a value
  `BSTL_ASSERT_NOW(a_value_kind, clk, rst, tok_valid && kind != K_INT, int_value == '0 && !overflow, "value on non-integer token")

  // tokens never span lines and lines count from one
  `BSTL_ASSERT_NOW(a_line, clk, rst, tok_valid, end_line == start_line && start_line != '0, "token line wrong")

endmodule

bind byte_stream_token_lexer_top bstl_checker u_checker (.*);

`default_nettype wire

// ===== verif/tb_byte_stream_token_lexer_top.sv =====
// Self-checking testbench for byte_stream_token_lexer_top: drives source bytes,
// predicts every token with its own scanner model and checks each token transfer.
// Depends on bstl_pkg and the lexer RTL; needs no files or arguments.
`timescale 1ns / 100ps

module tb_byte_stream_token_lexer_top;
  import bstl_pkg::*;

  // Scanner model plus the queue of tokens still owed by the block.
  class lexer_scoreboard;
    token_t            want_q[$];
    int unsigned       errors;
    mode_t             mode;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  tok_pos;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
    logic [COL_W-1:0]  tok_col;
    logic [VAL_W-1:0]  acc;
    logic              acc_ovf;
    logic              halted;

    function new();
      errors  = 0;
      mode    = MODE_IDLE;
      pos     = '0;
      tok_pos = '0;
      line    = LINE_W'(1);
      col     = COL_W'(1);
      tok_col = COL_W'(1);
      acc     = '0;
      acc_ovf = 1'b0;
      halted  = 1'b0;
    endfunction

    function bit is_digit(logic [CH_W-1:0] c);
      return c >= ASC_ZERO && c <= ASC_NINE;
    endfunction

    function bit is_word(logic [CH_W-1:0] c);
      return (c >= ASC_LOW_A && c <= ASC_LOW_Z) || (c >= ASC_UP_A && c <= ASC_UP_Z) ||
             c == ASC_UNDER;
    endfunction

    function bit op_code(input logic [CH_W-1:0] c, output kind_t k);
      op_code = 1'b1;
      case (c)
        ASC_PLUS:  k = K_PLUS;
        ASC_MINUS: k = K_MINUS;
        ASC_STAR:  k = K_STAR;
        ASC_SLASH: k = K_SLASH;
        ASC_PCT:   k = K_PERCENT;
        ASC_AMP:   k = K_AMP;
        ASC_BAR:   k = K_BAR;
        ASC_EQUAL: k = K_EQUAL;
        ASC_LPAR:  k = K_LPAREN;
        ASC_RPAR:  k = K_RPAREN;
        ASC_COMMA: k = K_COMMA;
        ASC_SEMI:  k = K_SEMI;
        default: begin
          k = K_EOF;
          op_code = 1'b0;
        end
      endcase
    endfunction

    // Offset and column stop at their ceiling.
    function void step_col();
      if (pos != '1) pos = pos + 1'b1;
      if (col != '1) col = col + 1'b1;
    endfunction

    function token_t make_tok(kind_t k, logic [POS_W-1:0] sp, logic [COL_W-1:0] sc,
                              logic [POS_W-1:0] ep, logic [COL_W-1:0] ec,
                              logic [VAL_W-1:0] v, logic o);
      token_t t;
      t.kind       = k;
      t.start_pos  = sp;
      t.start_line = line;
      t.start_col  = sc;
      t.end_pos    = ep;
      t.end_line   = line;
      t.end_col    = ec;
      t.int_value  = v;
      t.overflow   = o;
      t.last       = 1'b0;
      return t;
    endfunction

    // Advance the model by one accepted byte and queue the tokens it completes.
    function void note_byte(logic [CH_W-1:0] c);
      token_t           toks[2];
      int               n;
      logic [POS_W-1:0] epos;
      logic [COL_W-1:0] ecol;
      logic [VAL_W-1:0] d;
      kind_t            opk;
      n = 0;
      if (halted) return;
      epos = (pos != '0) ? pos - 1'b1 : '0;
      ecol = (col > COL_W'(1)) ? col - 1'b1 : COL_W'(1);
      d    = VAL_W'(c[3:0]);
      // A pending number or word closes on the first byte that cannot extend it.
      if (mode == MODE_INT) begin
        if (is_digit(c)) begin
          if (acc > ({VAL_W{1'b1}} - d) / VAL_W'(10)) acc_ovf = 1'b1;
          acc = acc * VAL_W'(10) + d;
          step_col();
          return;
        end
        toks[n] = make_tok(K_INT, tok_pos, tok_col, epos, ecol, acc, acc_ovf);
        n++;
        mode = MODE_IDLE;
      end else if (mode == MODE_IDENT) begin
        if (is_digit(c) || is_word(c)) begin
          step_col();
          return;
        end
        toks[n] = make_tok(K_IDENT, tok_pos, tok_col, epos, ecol, '0, 1'b0);
        n++;
        mode = MODE_IDLE;
      end else begin
        mode = MODE_IDLE;
      end

      if (c == ASC_LF) begin
        if (line != '1) line = line + 1'b1;
        col = COL_W'(1);
        if (pos != '1) pos = pos + 1'b1;
      end else if (c == ASC_SPACE || c == ASC_TAB || c == ASC_CR) begin
        step_col();
      end else if (is_digit(c)) begin
        mode    = MODE_INT;
        tok_pos = pos;
        tok_col = col;
        acc     = d;
        acc_ovf = 1'b0;
        step_col();
      end else if (is_word(c)) begin
        mode    = MODE_IDENT;
        tok_pos = pos;
        tok_col = col;
        step_col();
      end else if (op_code(c, opk)) begin
        toks[n] = make_tok(opk, pos, col, pos, col, '0, 1'b0);
        n++;
        step_col();
      end else begin
        toks[n] = make_tok((c == ASC_NUL) ? K_EOF : K_UNKNOWN, pos, col, pos, col, '0, 1'b0);
        n++;
        halted = 1'b1;
      end

      if (n > 0) toks[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) want_q.push_back(toks[i]);
    endfunction

    function void field_cmp(string name, logic [VAL_W-1:0] w, logic [VAL_W-1:0] g);
      if (w !== g) begin
        errors++;
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, w, g);
      end
    endfunction

    // Compare one token transfer with the oldest owed token.
    function void check_token(token_t got);
      token_t want;
      if (want_q.size() == 0) begin
        errors++;
        $display("%0t: token kind %0d expected none, got one at offset %0d",
                 $time, got.kind, got.start_pos);
        return;
      end
      want = want_q.pop_front();
      field_cmp("kind",       want.kind,       got.kind);
      field_cmp("start_pos",  want.start_pos,  got.start_pos);
      field_cmp("start_line", want.start_line, got.start_line);
      field_cmp("start_col",  want.start_col,  got.start_col);
      field_cmp("end_pos",    want.end_pos,    got.end_pos);
      field_cmp("end_line",   want.end_line,   got.end_line);
      field_cmp("end_col",    want.end_col,    got.end_col);
      field_cmp("int_value",  want.int_value,  got.int_value);
      field_cmp("overflow",   want.overflow,   got.overflow);
      field_cmp("last",       want.last,       got.last);
    endfunction
  endclass

  // Character pools for the random source text.
  localparam string WORD_CHARS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string DIGITS     = "0123456789";
  localparam string OP_CHARS   = "+-*/%&|=(),;";
  localparam string ODD_CHARS  = "!#$.:<>?@[]^{}~";

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              ch_valid  = 1'b0;
  logic              ch_stall;
  logic [CH_W-1:0]   ch        = '0;
  logic              tok_valid;
  logic              tok_stall = 1'b0;
  logic [KIND_W-1:0] kind;
  logic [POS_W-1:0]  start_pos;
  logic [LINE_W-1:0] start_line;
  logic [COL_W-1:0]  start_col;
  logic [POS_W-1:0]  end_pos;
  logic [LINE_W-1:0] end_line;
  logic [COL_W-1:0]  end_col;
  logic [VAL_W-1:0]  int_value;
  logic              overflow;
  logic              last;

  lexer_scoreboard board = new();
  int              idle_pct    = 9;   // chance in a hundred of a gap on either side
  int              hold_cycles = 0;   // pending receiver hold-off, counted down below
  int unsigned     n_sent      = 0;

  byte_stream_token_lexer_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .ch_valid   (ch_valid),
    .ch_stall   (ch_stall),
    .ch         (ch),
    .tok_valid  (tok_valid),
    .tok_stall  (tok_stall),
    .kind       (kind),
    .start_pos  (start_pos),
    .start_line (start_line),
    .start_col  (start_col),
    .end_pos    (end_pos),
    .end_line   (end_line),
    .end_col    (end_col),
    .int_value  (int_value),
    .overflow   (overflow),
    .last       (last)
  );

  always #5 clk = ~clk;

  // Hard stop: the slowest legal run needs well under a tenth of this.
  initial begin
    #5_000_000;
    $display("byte_stream_token_lexer_top: mismatch");
    $finish;
  end

  // Receiver: a long hold-off when one is requested, else random short stalls.
  always @(negedge clk) begin
    if (hold_cycles != 0) begin
      tok_stall <= 1'b1;
      hold_cycles--;
    end else begin
      tok_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
    end
  end

  // Sample both channels at the rising edge; note the input first so the model
  // is current, though no token can come from a byte taken at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (ch_valid && !ch_stall) board.note_byte(ch);
      if (tok_valid && !tok_stall)
        board.check_token('{kind: kind_t'(kind), start_pos: start_pos,
                            start_line: start_line, start_col: start_col,
                            end_pos: end_pos, end_line: end_line, end_col: end_col,
                            int_value: int_value, overflow: overflow, last: last});
    end
  end

  // Offer one byte and hold it until the transfer. Entered and left just after
  // a rising edge; valid stays high across back-to-back bytes.
  task automatic push_byte(input logic [CH_W-1:0] b);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      ch_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    ch_valid <= 1'b1;
    ch       <= b;
    do @(posedge clk); while (ch_stall);
    n_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // Drop valid and hold until every owed token has been taken.
  task automatic wait_drained();
    @(negedge clk);
    ch_valid <= 1'b0;
    while (board.want_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Random source text: mostly words, numbers and operators, sometimes glued
  // together so one byte closes a token and starts another.
  task automatic push_random_source(input int unsigned upto);
    int unsigned len;
    while (n_sent < upto) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          push_byte(WORD_CHARS[$urandom_range(WORD_CHARS.len() - 1)]);
          len = $urandom_range(11);
          repeat (len) begin
            if ($urandom_range(3) == 0) push_byte(DIGITS[$urandom_range(9)]);
            else push_byte(WORD_CHARS[$urandom_range(WORD_CHARS.len() - 1)]);
          end
        end
        3, 4: begin
          case ($urandom_range(9))
            0: push_text("18446744073709551615");   // largest value, no wrap
            1: push_text("18446744073709551616");   // first value that wraps
            2: begin
              len = $urandom_range(19, 26);
              repeat (len) push_byte(DIGITS[$urandom_range(9)]);
            end
            default: begin
              len = $urandom_range(1, 5);
              repeat (len) push_byte(DIGITS[$urandom_range(9)]);
            end
          endcase
        end
        5, 6, 7: push_byte(OP_CHARS[$urandom_range(OP_CHARS.len() - 1)]);
        8: begin
          case ($urandom_range(3))
            0: push_byte(ASC_TAB);
            1: push_byte(ASC_CR);
            2: push_byte(ASC_LF);
            default: push_byte(ASC_SPACE);
          endcase
        end
        default: begin
          // digit glued to an operator
          push_byte(DIGITS[$urandom_range(9)]);
          push_byte(OP_CHARS[$urandom_range(OP_CHARS.len() - 1)]);
        end
      endcase
      if ($urandom_range(1) == 0) begin
        case ($urandom_range(4))
          0: push_byte(ASC_LF);
          1: push_byte(ASC_TAB);
          default: push_byte(ASC_SPACE);
        endcase
      end
    end
  endtask

  initial begin
    logic [CH_W-1:0] stop_byte;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: word built from every class of word character, closed by an
    // operator; number closed by a letter; every kind of whitespace; all twelve
    // operators; word closed by a blank.
    push_text("_Az9+09a)");
    push_byte(ASC_CR);
    push_byte(ASC_TAB);
    push_byte(ASC_LF);
    push_text("-*/%&|=(,;Z ");

    push_random_source(n_sent + 100);

    // Receiver holds off while the sender keeps offering operators: the token
    // queue fills and the input must stall. Then drain fully.
    hold_cycles = 80;
    repeat (30) push_byte(OP_CHARS[$urandom_range(OP_CHARS.len() - 1)]);
    wait_drained();

    // A stretch with no gaps on either side.
    idle_pct = 0;
    push_random_source(n_sent + 150);
    idle_pct = 9;
    wait_drained();
    push_random_source(n_sent + 150);

    // A fresh line with a word, operator and number glued together.
    push_byte(ASC_LF);
    push_text("sat_x123+9876,");
    push_byte(ASC_LF);
    push_random_source(n_sent + 20);

    // Finish with end of file or an unknown byte, often right behind a pending
    // token; everything after must be dropped.
    if ($urandom_range(2) != 0) push_text($urandom_range(1) ? "ab" : "42");
    case ($urandom_range(2))
      0: stop_byte = ASC_NUL;
      1: stop_byte = 8'($urandom_range(128, 255));
      default: stop_byte = ODD_CHARS[$urandom_range(ODD_CHARS.len() - 1)];
    endcase
    push_byte(stop_byte);
    push_byte(8'hFF);
    push_byte(8'h80);
    push_byte(ASC_NUL);
    push_byte(ASC_PLUS);
    repeat (4) push_byte(8'($urandom));

    wait_drained();
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("byte_stream_token_lexer_top: match");
    end else begin
      $display("byte_stream_token_lexer_top: mismatch");
    end
    $finish;
  end

endmodule
